/* design/rpn_pkg.sv */
// Shared types and constants of the RPN stack calculator.
// Used by the front end, the command queue, the execution unit and the top level.
package rpn_pkg;

   localparam int StackDepth = 128;
   localparam int SpW = $clog2(StackDepth + 1);
   localparam int AddrW = $clog2(StackDepth);
   localparam int FractionBits = 16;
   localparam int MaxFractionDigits = 6;
   localparam int QueueDepth = 4;
   localparam int QPtrW = $clog2(QueueDepth);

   localparam logic [63:0] IntLimit = 64'h7FFF_FFFF_FFFF_FFFF >> FractionBits;

   typedef enum logic [2:0] {
      KIND_VALUE = 3'd0,
      KIND_FULL = 3'd1,
      KIND_EMPTY = 3'd2,
      KIND_ZERO_DIV = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_PRINT,
      OP_UNKNOWN
   } op_type;

   // One classified command; a number push may be followed by an operator.
   typedef struct packed {
      logic push_valid;
      logic [63:0] push_value;
      op_type op;
      logic [7:0] bad_char;
   } cmd_type;

   typedef enum logic [3:0] {
      EX_IDLE,
      EX_PUSH,
      EX_POP_B,
      EX_WAIT_B,
      EX_POP_A,
      EX_WAIT_A,
      EX_CALC,
      EX_MUL,
      EX_DIV,
      EX_STORE,
      EX_EMIT
   } ex_state_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CONV,
      FE_SEND
   } fe_state_type;

   function automatic logic [63:0] pow_ten(input logic [3:0] n);
      case (n)
         4'd0: pow_ten = 64'd1;
         4'd1: pow_ten = 64'd10;
         4'd2: pow_ten = 64'd100;
         4'd3: pow_ten = 64'd1000;
         4'd4: pow_ten = 64'd10000;
         4'd5: pow_ten = 64'd100000;
         4'd6: pow_ten = 64'd1000000;
         4'd7: pow_ten = 64'd10000000;
         4'd8: pow_ten = 64'd100000000;
         default: pow_ten = 64'd1000000000;
      endcase
   endfunction

endpackage

/* design/rpn_front.sv */
// Front end: accepts characters, assembles numbers and classifies tokens.
// Depends on rpn_pkg; the fraction conversion uses a serial divider.
module rpn_front (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input logic [7:0] in_char,
   input logic in_eoi,
   output logic cmd_valid,
   input logic cmd_ready,
   output rpn_pkg::cmd_type cmd
);
   import rpn_pkg::*;

   fe_state_type state_ff, state_in;
   logic in_number_ff, in_number_in;
   logic seen_point_ff, seen_point_in;
   logic [63:0] int_part_ff, int_part_in;
   logic [19:0] frac_val_ff, frac_val_in;
   logic [2:0] frac_cnt_ff, frac_cnt_in;
   cmd_type cmd_ff, cmd_in;
   op_type pend_op_ff, pend_op_in;
   logic [7:0] pend_bad_ff, pend_bad_in;
   logic [63:0] int_hold_ff, int_hold_in;
   // Restoring divider for the fraction part.
   logic [63:0] div_rem_ff, div_rem_in;
   logic [63:0] div_quo_ff, div_quo_in;
   logic [63:0] div_den_ff, div_den_in;
   logic [5:0] div_cnt_ff, div_cnt_in;

   logic is_digit;
   logic [3:0] dgt;
   logic [63:0] lim_div;
   logic [63:0] int_mul;
   logic [64:0] trial;
   op_type tok_op;
   logic accept;

   assign in_ready = (state_ff == FE_IDLE);
   assign accept = in_valid && in_ready;
   assign cmd_valid = (state_ff == FE_SEND);
   assign cmd = cmd_ff;

   assign is_digit = (in_char >= 8'h30) && (in_char <= 8'h39);
   assign dgt = 4'(in_char - 8'h30);
   assign int_mul = (int_part_ff << 3) + (int_part_ff << 1) + 64'(dgt);
   assign trial = {div_rem_ff, div_quo_ff[63]} - {1'b0, div_den_ff};

   // Saturation limit for each digit; every entry is a constant.
   always_comb begin
      case (dgt)
         4'd0: lim_div = IntLimit / 64'd10;
         4'd1: lim_div = (IntLimit - 64'd1) / 64'd10;
         4'd2: lim_div = (IntLimit - 64'd2) / 64'd10;
         4'd3: lim_div = (IntLimit - 64'd3) / 64'd10;
         4'd4: lim_div = (IntLimit - 64'd4) / 64'd10;
         4'd5: lim_div = (IntLimit - 64'd5) / 64'd10;
         4'd6: lim_div = (IntLimit - 64'd6) / 64'd10;
         4'd7: lim_div = (IntLimit - 64'd7) / 64'd10;
         4'd8: lim_div = (IntLimit - 64'd8) / 64'd10;
         default: lim_div = (IntLimit - 64'd9) / 64'd10;
      endcase
   end

   always_comb begin
      case (in_char)
         8'h2B: tok_op = OP_ADD;
         8'h2D: tok_op = OP_SUB;
         8'h2A: tok_op = OP_MUL;
         8'h2F: tok_op = OP_DIV;
         8'h0A: tok_op = OP_PRINT;
         8'h20, 8'h09, 8'h2E: tok_op = OP_NONE;
         default: tok_op = is_digit ? OP_NONE : OP_UNKNOWN;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      in_number_in = in_number_ff;
      seen_point_in = seen_point_ff;
      int_part_in = int_part_ff;
      frac_val_in = frac_val_ff;
      frac_cnt_in = frac_cnt_ff;
      cmd_in = cmd_ff;
      pend_op_in = pend_op_ff;
      pend_bad_in = pend_bad_ff;
      int_hold_in = int_hold_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         FE_IDLE: begin
            if (accept) begin
               if (in_number_ff && (in_eoi || !(is_digit ||
                     (in_char == 8'h2E && !seen_point_ff)))) begin
                  // Number ends: convert, then send with the following token.
                  pend_op_in = in_eoi ? OP_NONE : tok_op;
                  pend_bad_in = in_char;
                  int_hold_in = int_part_ff << FractionBits;
                  div_rem_in = '0;
                  div_quo_in = 64'(frac_val_ff) << FractionBits;
                  div_den_in = pow_ten(4'(frac_cnt_ff));
                  div_cnt_in = '0;
                  int_part_in = '0;
                  frac_val_in = '0;
                  frac_cnt_in = '0;
                  // A second point starts a new number.
                  in_number_in = !in_eoi && (is_digit || in_char == 8'h2E);
                  seen_point_in = !in_eoi && (in_char == 8'h2E);
                  if (!in_eoi && is_digit)
                     int_part_in = 64'(dgt);
                  state_in = FE_CONV;
               end else if (!in_eoi && (is_digit || in_char == 8'h2E)) begin
                  in_number_in = 1'b1;
                  if (in_char == 8'h2E) begin
                     seen_point_in = 1'b1;
                  end else if (!seen_point_ff) begin
                     int_part_in = (int_part_ff > lim_div) ? IntLimit : int_mul;
                  end else if (frac_cnt_ff < 3'(MaxFractionDigits)) begin
                     frac_val_in = 20'((frac_val_ff << 3) + (frac_val_ff << 1) + 20'(dgt));
                     frac_cnt_in = frac_cnt_ff + 3'd1;
                  end
               end else if (!in_eoi && tok_op != OP_NONE) begin
                  cmd_in.push_valid = 1'b0;
                  cmd_in.push_value = '0;
                  cmd_in.op = tok_op;
                  cmd_in.bad_char = (tok_op == OP_UNKNOWN) ? in_char : 8'd0;
                  state_in = FE_SEND;
               end
            end
         end
         FE_CONV: begin
            div_cnt_in = div_cnt_ff + 6'd1;
            if (!trial[64]) begin
               div_rem_in = trial[63:0];
               div_quo_in = {div_quo_ff[62:0], 1'b1};
            end else begin
               div_rem_in = {div_rem_ff[62:0], div_quo_ff[63]};
               div_quo_in = {div_quo_ff[62:0], 1'b0};
            end
            if (div_cnt_ff == 6'd63) begin
               cmd_in.push_valid = 1'b1;
               cmd_in.push_value = int_hold_ff + div_quo_in;
               cmd_in.op = pend_op_ff;
               cmd_in.bad_char = (pend_op_ff == OP_UNKNOWN) ? pend_bad_ff : 8'd0;
               state_in = FE_SEND;
            end
         end
         FE_SEND: begin
            if (cmd_ready)
               state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         in_number_ff <= 1'b0;
         seen_point_ff <= 1'b0;
         int_part_ff <= '0;
         frac_val_ff <= '0;
         frac_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         in_number_ff <= in_number_in;
         seen_point_ff <= seen_point_in;
         int_part_ff <= int_part_in;
         frac_val_ff <= frac_val_in;
         frac_cnt_ff <= frac_cnt_in;
      end
      cmd_ff <= cmd_in;
      pend_op_ff <= pend_op_in;
      pend_bad_ff <= pend_bad_in;
      int_hold_ff <= int_hold_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
   end

endmodule

/* design/rpn_queue.sv */
// Short command queue between the front end and the execution unit.
// Depends on rpn_pkg for the command type and depth.
module rpn_queue (
   input logic clock,
   input logic reset,
   input logic wr_valid,
   output logic wr_ready,
   input rpn_pkg::cmd_type wr_data,
   output logic rd_valid,
   input logic rd_ready,
   output rpn_pkg::cmd_type rd_data
);
   import rpn_pkg::*;

   cmd_type entry_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0] count_ff;
   logic do_wr, do_rd;

   assign wr_ready = (count_ff != (QPtrW+1)'(QueueDepth));
   assign rd_valid = (count_ff != '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_rd)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QPtrW+1)'(do_wr) - (QPtrW+1)'(do_rd);
      end
      if (do_wr)
         entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

/* design/rpn_exec.sv */
// Execution unit: value stack, saturating arithmetic and result output.
// Depends on rpn_pkg; multiply and divide share one serial datapath.
module rpn_exec (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_ready,
   input rpn_pkg::cmd_type cmd,
   output logic out_valid,
   input logic out_ready,
   output logic [2:0] out_kind,
   output logic [63:0] out_value,
   output logic [7:0] out_bad,
   output logic out_last
);
   import rpn_pkg::*;

   logic [63:0] stack_mem [StackDepth];
   logic [63:0] rd_data_ff;
   logic rd_hit_ff;

   ex_state_type state_ff, state_in;
   logic [SpW-1:0] sp_ff, sp_in;
   cmd_type cur_ff, cur_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic store_ff, store_in;
   // Up to two pending reports, sent in order.
   logic [1:0] nres_ff, nres_in;
   logic [2:0] k0_ff, k0_in, k1_ff, k1_in;
   logic [63:0] v0_ff, v0_in, v1_ff, v1_in;
   logic [7:0] b0_ff, b0_in, b1_ff, b1_in;
   logic [1:0] sent_ff, sent_in;
   // Shared serial unit: shift-add multiply or restoring divide.
   logic [127:0] acc_ff, acc_in;
   logic [63:0] mag_b_ff, mag_b_in;
   logic [63:0] rem_ff, rem_in;
   logic [7:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;

   logic is_arith, pop_req, rd_en, wr_en;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic [63:0] mag_a, mag_bv, sum, dif;
   logic [64:0] msum;
   logic [63:0] rshift;
   logic [65:0] dtrial;
   logic rep_en;
   kind_type rep_kind;
   logic [63:0] rep_value;
   logic [7:0] rep_bad;

   function automatic logic [63:0] abs64(input logic [63:0] v);
      abs64 = v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] from_mag(input logic [63:0] m, input logic n);
      if (n)
         from_mag = m[63] ? 64'h8000_0000_0000_0000 : (64'd0 - m);
      else
         from_mag = m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
   endfunction

   assign mag_a = abs64(a_ff);
   assign mag_bv = abs64(b_ff);
   assign sum = a_ff + b_ff;
   assign dif = a_ff - b_ff;
   assign msum = {1'b0, acc_ff[127:64]} + {1'b0, mag_b_ff};
   assign rshift = {rem_ff[62:0], acc_ff[127]};
   assign dtrial = {1'b0, rem_ff[63], rshift} - {2'b00, mag_b_ff};

   assign cmd_ready = (state_ff == EX_IDLE);
   assign out_valid = (state_ff == EX_EMIT);
   assign out_kind = (sent_ff == 2'd0) ? k0_ff : k1_ff;
   assign out_value = (sent_ff == 2'd0) ? v0_ff : v1_ff;
   assign out_bad = (sent_ff == 2'd0) ? b0_ff : b1_ff;
   assign out_last = (2'(sent_ff + 2'd1) == nres_ff);

   assign is_arith = (cur_ff.op == OP_ADD) || (cur_ff.op == OP_SUB)
                     || (cur_ff.op == OP_MUL) || (cur_ff.op == OP_DIV);

   // The first operand is not popped after a zero divisor.
   always_comb begin
      case (state_ff)
         EX_POP_B: pop_req = is_arith || (cur_ff.op == OP_PRINT);
         EX_POP_A: pop_req = is_arith && !(cur_ff.op == OP_DIV && b_ff == '0);
         default: pop_req = 1'b0;
      endcase
   end

   assign rd_en = pop_req && sp_ff != '0;
   assign rd_addr = AddrW'(sp_ff - 1'b1);
   assign wr_en = (state_ff == EX_STORE) && store_ff
                  && sp_ff != SpW'(StackDepth);
   assign wr_addr = AddrW'(sp_ff);

   always_ff @(posedge clock) begin
      if (wr_en)
         stack_mem[wr_addr] <= res_ff;
      if (rd_en)
         rd_data_ff <= stack_mem[rd_addr];
      rd_hit_ff <= rd_en;
   end

   // Report raised by the current step, at most one per cycle.
   always_comb begin
      rep_en = 1'b0;
      rep_kind = KIND_VALUE;
      rep_value = '0;
      rep_bad = '0;
      case (state_ff)
         EX_POP_B: begin
            if (pop_req && sp_ff == '0) begin
               rep_en = 1'b1;
               rep_kind = KIND_EMPTY;
            end
         end
         EX_POP_A: begin
            if (cur_ff.op == OP_PRINT) begin
               rep_en = 1'b1;
               rep_kind = KIND_VALUE;
               rep_value = b_ff;
            end else if (cur_ff.op == OP_DIV && b_ff == '0) begin
               rep_en = 1'b1;
               rep_kind = KIND_ZERO_DIV;
            end else if (pop_req && sp_ff == '0) begin
               rep_en = 1'b1;
               rep_kind = KIND_EMPTY;
            end
         end
         EX_CALC: begin
            if (cur_ff.op == OP_UNKNOWN) begin
               rep_en = 1'b1;
               rep_kind = KIND_UNKNOWN;
               rep_bad = cur_ff.bad_char;
            end
         end
         EX_STORE: begin
            if (store_ff && sp_ff == SpW'(StackDepth)) begin
               rep_en = 1'b1;
               rep_kind = KIND_FULL;
            end
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE: if (cmd_valid) state_in = cmd.push_valid ? EX_PUSH : EX_POP_B;
         EX_PUSH: state_in = EX_STORE;
         EX_POP_B: state_in = EX_WAIT_B;
         EX_WAIT_B: state_in = EX_POP_A;
         EX_POP_A: state_in = EX_WAIT_A;
         EX_WAIT_A: state_in = EX_CALC;
         EX_CALC: begin
            case (cur_ff.op)
               OP_MUL: state_in = EX_MUL;
               OP_DIV: state_in = (b_ff != '0) ? EX_DIV : EX_STORE;
               default: state_in = EX_STORE;
            endcase
         end
         EX_MUL: if (cnt_ff == 8'd64) state_in = EX_STORE;
         EX_DIV: if (cnt_ff == 8'd128) state_in = EX_STORE;
         EX_STORE: begin
            // A number push followed by an operator goes on with the operator.
            if (cur_ff.push_valid && cur_ff.op != OP_NONE)
               state_in = EX_POP_B;
            else if (nres_in != 2'd0)
               state_in = EX_EMIT;
            else
               state_in = EX_IDLE;
         end
         EX_EMIT: if (out_ready && out_last) state_in = EX_IDLE;
         default: state_in = EX_IDLE;
      endcase
   end

   // Datapath and outputs of each step.
   always_comb begin
      sp_in = sp_ff;
      cur_in = cur_ff;
      a_in = a_ff;
      b_in = b_ff;
      res_in = res_ff;
      store_in = store_ff;
      nres_in = nres_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      sent_in = sent_ff;
      acc_in = acc_ff;
      mag_b_in = mag_b_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      case (state_ff)
         EX_IDLE: begin
            if (cmd_valid) begin
               cur_in = cmd;
               nres_in = '0;
               sent_in = '0;
            end
         end
         EX_PUSH: begin
            res_in = cur_ff.push_value;
            store_in = 1'b1;
         end
         EX_POP_B, EX_POP_A: begin
            if (rd_en)
               sp_in = sp_ff - 1'b1;
         end
         EX_WAIT_B: b_in = rd_hit_ff ? rd_data_ff : 64'd0;
         EX_WAIT_A: a_in = rd_hit_ff ? rd_data_ff : 64'd0;
         EX_CALC: begin
            store_in = 1'b1;
            neg_in = a_ff[63] ^ b_ff[63];
            cnt_in = '0;
            rem_in = '0;
            case (cur_ff.op)
               OP_ADD: res_in = (a_ff[63] == b_ff[63] && sum[63] != a_ff[63]) ?
                          (a_ff[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                          : sum;
               OP_SUB: res_in = (a_ff[63] != b_ff[63] && dif[63] != a_ff[63]) ?
                          (a_ff[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                          : dif;
               OP_MUL: begin
                  acc_in = {64'd0, mag_bv};
                  mag_b_in = mag_a;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     store_in = 1'b0;
                  end else begin
                     acc_in = {64'd0, mag_a} << FractionBits;
                     mag_b_in = mag_bv;
                  end
               end
               default: begin
                  res_in = '0;
                  store_in = 1'b0;
               end
            endcase
         end
         EX_MUL: begin
            if (cnt_ff == 8'd64) begin
               res_in = from_mag((acc_ff[127:64 + FractionBits] != '0) ?
                  64'hFFFF_FFFF_FFFF_FFFF : acc_ff[FractionBits +: 64], neg_ff);
            end else begin
               cnt_in = cnt_ff + 8'd1;
               if (acc_ff[0])
                  acc_in = {msum, acc_ff[63:1]};
               else
                  acc_in = {1'b0, acc_ff[127:1]};
            end
         end
         EX_DIV: begin
            // acc shifts the dividend out at the top and the quotient in below.
            if (cnt_ff == 8'd128) begin
               res_in = from_mag((acc_ff[127:64] != '0) ?
                  64'hFFFF_FFFF_FFFF_FFFF : acc_ff[63:0], neg_ff);
            end else begin
               cnt_in = cnt_ff + 8'd1;
               if (!dtrial[65]) begin
                  rem_in = dtrial[63:0];
                  acc_in = {acc_ff[126:0], 1'b1};
               end else begin
                  rem_in = rshift;
                  acc_in = {acc_ff[126:0], 1'b0};
               end
            end
         end
         EX_STORE: begin
            store_in = 1'b0;
            if (wr_en)
               sp_in = sp_ff + 1'b1;
            if (cur_ff.push_valid && cur_ff.op != OP_NONE)
               cur_in.push_valid = 1'b0;
         end
         EX_EMIT: begin
            if (out_ready)
               sent_in = sent_ff + 2'd1;
         end
         default: ;
      endcase
      if (rep_en && nres_ff != 2'd2) begin
         if (nres_ff == 2'd0) begin
            k0_in = rep_kind;
            v0_in = rep_value;
            b0_in = rep_bad;
         end else begin
            k1_in = rep_kind;
            v1_in = rep_value;
            b1_in = rep_bad;
         end
         nres_in = nres_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
         sp_ff <= '0;
         nres_ff <= '0;
         sent_ff <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         nres_ff <= nres_in;
         sent_ff <= sent_in;
      end
      cur_ff <= cur_in;
      a_ff <= a_in;
      b_ff <= b_in;
      res_ff <= res_in;
      store_ff <= store_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      v0_ff <= v0_in;
      v1_ff <= v1_in;
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      acc_ff <= acc_in;
      mag_b_ff <= mag_b_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

/* design/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: front end, command queue and
// execution unit. Depends on rpn_pkg, rpn_front, rpn_queue and rpn_exec.
//
// One ASCII character is taken per transfer on the req_ side. Results
// (printed values and error reports, up to two per character, the last one
// flagged by rsp_tlast) leave on the rsp_ side. A character that ends a
// number passes through the serial fraction conversion in the front end.
// In the execution unit a push goes through EX_PUSH and EX_STORE, an
// operator through EX_POP_B, EX_WAIT_B, EX_POP_A, EX_WAIT_A, EX_CALC and
// EX_STORE; multiply and divide add the serial 64-step multiply and
// 128-step divide. Each result is held on the rsp_ side until taken.
// The command queue lets the front end keep parsing while the execution unit works.
module rpn_stack_calculator (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,  // [7:0] char_code
   input logic req_tuser,        // [0] end_of_input
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [79:0] rsp_tdata, // [2:0] kind, [66:3] value, [74:67] bad_char
   output logic rsp_tlast
);
   import rpn_pkg::*;

   logic fe_valid, fe_ready, q_valid, q_ready;
   cmd_type fe_cmd, q_cmd;
   logic [2:0] kind;
   logic [63:0] value;
   logic [7:0] bad;

   rpn_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata), .in_eoi(req_tuser),
      .cmd_valid(fe_valid), .cmd_ready(fe_ready), .cmd(fe_cmd)
   );

   rpn_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_data(fe_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   rpn_exec u_exec (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(kind), .out_value(value), .out_bad(bad), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, bad, value, kind};

endmodule
